// ===== rtl/asc_pkg.sv =====
// annular sector containment: shared package
// configuration register indexes and port widths; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package asc_pkg;

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_START_DIR_X = 3'd2,
        CFG_START_DIR_Y = 3'd3,
        CFG_END_DIR_X   = 3'd4,
        CFG_END_DIR_Y   = 3'd5,
        CFG_OUTER_RAD   = 3'd6,
        CFG_INNER_RAD   = 3'd7
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/annular_sector_containment_core.sv =====
// annular sector containment: top level
// input offset register, product register, result register; uses asc_pkg,
// asc_cfg_regs and asc_corner_check
// beat passes all registers above to the strobe; one beat accepted every cycle
// the product stage holds twelve multipliers shared by the four corners
// busy is always low; results cannot be stalled
// synchronous active-low reset clears configuration to zero and drops pending beats
`timescale 1ns / 1ps
`default_nettype none

module annular_sector_containment_core #(
    parameter int COORD_BITS = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                i_func,
    input  wire signed [COORD_BITS-1:0]        i_first_x,
    input  wire signed [COORD_BITS-1:0]        i_first_y,
    input  wire signed [COORD_BITS-1:0]        i_second_x,
    input  wire signed [COORD_BITS-1:0]        i_second_y,
    input  wire                                i_cfg_we,
    input  wire [asc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire [COORD_BITS-1:0]               i_cfg_data,
    output logic                               o_strobe,
    output logic                               o_inside_res
);
    import asc_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int DW = W + 1;
    localparam int SQ = 2*W + 3;
    localparam int PW = 2*W + 1;

    logic signed [W-1:0] cx, cy, sx, sy, ex, ey;
    logic [2*W-1:0]      outer2, inner2;
    logic                wide;

    asc_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_center_x (cx),
        .o_center_y (cy),
        .o_start_x  (sx),
        .o_start_y  (sy),
        .o_end_x    (ex),
        .o_end_y    (ey),
        .o_outer2   (outer2),
        .o_inner2   (inner2),
        .o_wide     (wide)
    );

    assign busy = 1'b0;

    // stage 0: offsets from apex
    logic                 r_v0, r_func0;
    logic signed [DW-1:0] r_dx [2];
    logic signed [DW-1:0] r_dy [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func0  <= i_func;
        r_dx[0]  <= DW'(i_first_x) - DW'(cx);
        r_dx[1]  <= DW'(i_second_x) - DW'(cx);
        r_dy[0]  <= DW'(i_first_y) - DW'(cy);
        r_dy[1]  <= DW'(i_second_y) - DW'(cy);
    end

    // stage 1: squares and cross products
    logic                 r_v1, r_func1;
    logic signed [SQ-1:0] r_sqx [2];
    logic signed [SQ-1:0] r_sqy [2];
    logic signed [PW-1:0] r_sdy [2];
    logic signed [PW-1:0] r_sdx [2];
    logic signed [PW-1:0] r_dxe [2];
    logic signed [PW-1:0] r_dye [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func1 <= r_func0;
        for (int i = 0; i < 2; i++) begin
            r_sqx[i] <= SQ'(r_dx[i]) * SQ'(r_dx[i]);
            r_sqy[i] <= SQ'(r_dy[i]) * SQ'(r_dy[i]);
            r_sdy[i] <= PW'(sx) * PW'(r_dy[i]);
            r_sdx[i] <= PW'(sy) * PW'(r_dx[i]);
            r_dxe[i] <= PW'(r_dx[i]) * PW'(ey);
            r_dye[i] <= PW'(r_dy[i]) * PW'(ex);
        end
    end

    // stage 2: corner tests; corners (x0,y0) (x1,y1) (x0,y1) (x1,y0)
    logic [3:0] corner_ok;

    for (genvar k = 0; k < 4; k++) begin : g_corner
        localparam int XI = (k == 1 || k == 3) ? 1 : 0;
        localparam int YI = (k == 1 || k == 2) ? 1 : 0;

        asc_corner_check #(.COORD_BITS(COORD_BITS)) u_corner (
            .i_sq_x   (r_sqx[XI]),
            .i_sq_y   (r_sqy[YI]),
            .i_sdy    (r_sdy[YI]),
            .i_sdx    (r_sdx[XI]),
            .i_dxe    (r_dxe[XI]),
            .i_dye    (r_dye[YI]),
            .i_outer2 (outer2),
            .i_inner2 (inner2),
            .i_wide   (wide),
            .o_inside (corner_ok[k])
        );
    end

    logic r_strobe, r_inside;
    logic n_inside;

    assign n_inside = r_func1 ? (&corner_ok) : corner_ok[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inside <= n_inside;
    end

    assign o_strobe     = r_strobe;
    assign o_inside_res = r_inside;

endmodule

`default_nettype wire

// ===== rtl/asc_cfg_regs.sv =====
// annular sector containment: sector configuration registers
// holds the eight registers plus registered radius squares and wide-sector flag; uses asc_pkg
`timescale 1ns / 1ps
`default_nettype none

module asc_cfg_regs #(
    parameter int COORD_BITS = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire [asc_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  wire [COORD_BITS-1:0]                  i_cfg_data,
    output logic signed [COORD_BITS-1:0]          o_center_x,
    output logic signed [COORD_BITS-1:0]          o_center_y,
    output logic signed [COORD_BITS-1:0]          o_start_x,
    output logic signed [COORD_BITS-1:0]          o_start_y,
    output logic signed [COORD_BITS-1:0]          o_end_x,
    output logic signed [COORD_BITS-1:0]          o_end_y,
    output logic [2*COORD_BITS-1:0]               o_outer2,
    output logic [2*COORD_BITS-1:0]               o_inner2,
    output logic                                  o_wide
);
    import asc_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int PW = 2*W;
    localparam int XW = 2*W + 1;

    logic signed [W-1:0]  r_cx, r_cy, r_sx, r_sy, r_ex, r_ey;
    logic [W-1:0]         r_ro, r_ri;
    logic [PW-1:0]        r_outer2, r_inner2;
    logic                 r_wide;
    logic [PW-1:0]        n_outer2, n_inner2;
    logic                 n_wide;
    logic signed [XW-1:0] cse, dse;
    t_cfg_idx             cfg_idx;

    assign cfg_idx = t_cfg_idx'(i_cfg_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_sx <= '0;
            r_sy <= '0;
            r_ex <= '0;
            r_ey <= '0;
            r_ro <= '0;
            r_ri <= '0;
        end else if (i_cfg_we) begin
            unique case (cfg_idx)
                CFG_CENTER_X:    r_cx <= $signed(i_cfg_data);
                CFG_CENTER_Y:    r_cy <= $signed(i_cfg_data);
                CFG_START_DIR_X: r_sx <= $signed(i_cfg_data);
                CFG_START_DIR_Y: r_sy <= $signed(i_cfg_data);
                CFG_END_DIR_X:   r_ex <= $signed(i_cfg_data);
                CFG_END_DIR_Y:   r_ey <= $signed(i_cfg_data);
                CFG_OUTER_RAD:   r_ro <= i_cfg_data;
                CFG_INNER_RAD:   r_ri <= i_cfg_data;
            endcase
        end
    end

    // wide sector: start and end exactly opposite
    always_comb begin
        n_outer2 = PW'(r_ro) * PW'(r_ro);
        n_inner2 = PW'(r_ri) * PW'(r_ri);
        cse      = XW'(r_sx) * XW'(r_ey) - XW'(r_sy) * XW'(r_ex);
        dse      = XW'(r_sx) * XW'(r_ex) + XW'(r_sy) * XW'(r_ey);
        n_wide   = (cse == '0) && dse[XW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outer2 <= '0;
            r_inner2 <= '0;
            r_wide   <= 1'b0;
        end else begin
            r_outer2 <= n_outer2;
            r_inner2 <= n_inner2;
            r_wide   <= n_wide;
        end
    end

    assign o_center_x = r_cx;
    assign o_center_y = r_cy;
    assign o_start_x  = r_sx;
    assign o_start_y  = r_sy;
    assign o_end_x    = r_ex;
    assign o_end_y    = r_ey;
    assign o_outer2   = r_outer2;
    assign o_inner2   = r_inner2;
    assign o_wide     = r_wide;

endmodule

`default_nettype wire

// ===== rtl/asc_corner_check.sv =====
// annular sector containment: per-corner radius and side tests
// combines registered squares and cross terms of one corner; no package use
`timescale 1ns / 1ps
`default_nettype none

module asc_corner_check #(
    parameter int COORD_BITS = 16
) (
    input  wire signed [2*COORD_BITS+2:0]  i_sq_x,
    input  wire signed [2*COORD_BITS+2:0]  i_sq_y,
    input  wire signed [2*COORD_BITS:0]    i_sdy,
    input  wire signed [2*COORD_BITS:0]    i_sdx,
    input  wire signed [2*COORD_BITS:0]    i_dxe,
    input  wire signed [2*COORD_BITS:0]    i_dye,
    input  wire [2*COORD_BITS-1:0]         i_outer2,
    input  wire [2*COORD_BITS-1:0]         i_inner2,
    input  wire                            i_wide,
    output logic                           o_inside
);
    localparam int W  = COORD_BITS;
    localparam int SQ = 2*W + 3;
    localparam int CR = 2*W + 2;

    logic signed [SQ-1:0] dist_sq, outer2, inner2;
    logic signed [CR-1:0] cs, ce;
    logic                 in_ring, cs_neg, ce_neg, cs_zero, ce_zero, in_side;

    always_comb begin
        dist_sq = i_sq_x + i_sq_y;
        outer2  = $signed({3'b000, i_outer2});
        inner2  = $signed({3'b000, i_inner2});
        cs      = CR'(i_sdy) - CR'(i_sdx);
        ce      = CR'(i_dxe) - CR'(i_dye);
        in_ring = (dist_sq <= outer2) && (dist_sq >= inner2);
        cs_neg  = cs[CR-1];
        ce_neg  = ce[CR-1];
        cs_zero = (cs == '0);
        ce_zero = (ce == '0);
        if (i_wide) begin
            in_side = !((cs_neg || cs_zero) && (ce_neg || ce_zero));
        end else begin
            in_side = !cs_neg && !ce_neg;
        end
        o_inside = in_ring && in_side;
    end

endmodule

`default_nettype wire
